[sv/ferl_pkg.sv]
`timescale 1ns / 1ps

package ferl_pkg;

	// Command codes; code 3 has no meaning and answers like a missed read.
	typedef enum logic [1:0] {
		CMD_LOG   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} ferl_cmd_t;

	// One stored fault event.
	typedef struct packed {
		logic [63:0] stamp;
		logic [7:0]  kind;
		logic [15:0] source;
		logic [31:0] serial;
	} ferl_entry_t;

	// Strobes from the pointer logic to the event store.
	typedef struct packed {
		logic wr;
		logic rd;
	} ferl_mem_ctl_t;

endpackage

[sv/fault_event_ring_log.sv]
`timescale 1ns / 1ps

// Circular trace buffer of fault events.
// Input channel (in_valid / in_stall): one command per transaction - log an
// event, read the event at read_index counted from the oldest held entry,
// or clear. Output channel (out_valid / out_stall): exactly one result
// transaction per command, in order. found is set only for a read that
// hits a held entry; the event fields are zero otherwise. entry_total
// carries the number of held events after the command.
// Timing: a taken command sits in the input register, is executed against
// the pointer logic and the store, and its result goes to the output
// register. One command per cycle is sustained while the receiver does
// not stall; the store does at most one write or one read per command, so
// its single port sets the rate.
// Once full, the oldest entry is overwritten. After reset the log is
// empty and the sequence counter is zero; the store is not swept, as only
// entries logged since the last clear can ever be read.
// While the receiver stalls, the result is held and the input register can
// still take one more command; after that in_stall rises.
module fault_event_ring_log import ferl_pkg::*; #(
	parameter int LOG_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  event_kind,
	input  logic [15:0] source_id,
	input  logic [63:0] stamp,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [4:0]  entry_total,
	output logic [63:0] out_stamp,
	output logic [7:0]  out_kind,
	output logic [15:0] out_source,
	output logic [31:0] out_serial
);

	localparam int PW = $clog2(LOG_DEPTH);
	localparam int CW = $clog2(LOG_DEPTH + 1);

	// input register
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  kind_s1;
	logic [15:0] source_s1;
	logic [63:0] stamp_s1;
	logic [7:0]  index_s1;

	// result register (the event itself sits in the store's read register)
	logic          out_valid_s2;
	logic          found_s2;
	logic [CW-1:0] total_s2;

	logic          adv;
	logic          fire;
	ferl_mem_ctl_t mem_ctl;
	logic [PW-1:0] addr;
	logic [31:0]   serial;
	logic          hit;
	logic [CW-1:0] total;
	ferl_entry_t   wdata;
	ferl_entry_t   rdata;
	logic [CW+4:0] total_ext;

	// Result register frees up when empty or when its transaction goes out.
	assign adv      = !out_valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= cmd;
			kind_s1   <= event_kind;
			source_s1 <= source_id;
			stamp_s1  <= stamp;
			index_s1  <= read_index;
		end
	end

	ferl_ctrl #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.cmd        (cmd_s1),
		.read_index (index_s1),
		.mem_ctl    (mem_ctl),
		.addr       (addr),
		.serial     (serial),
		.found      (hit),
		.total      (total)
	);

	assign wdata.stamp  = stamp_s1;
	assign wdata.kind   = kind_s1;
	assign wdata.source = source_s1;
	assign wdata.serial = serial;

	ferl_store #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.addr    (addr),
		.wdata   (wdata),
		.rdata   (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			found_s2 <= hit;
			total_s2 <= total;
		end
	end

	// Event fields read as zero unless a read hit.
	assign out_valid   = out_valid_s2;
	assign found       = found_s2;
	assign total_ext   = {5'd0, total_s2};
	assign entry_total = total_ext[4:0];
	assign out_stamp   = found_s2 ? rdata.stamp : '0;
	assign out_kind    = found_s2 ? rdata.kind : '0;
	assign out_source  = found_s2 ? rdata.source : '0;
	assign out_serial  = found_s2 ? rdata.serial : '0;

`ifndef SYNTHESIS
	a_hit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && found_s2 |-> total_s2 != '0)
		else $error("hit reported on an empty log");

	a_blocked_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_s2 && out_stall |=> valid_s1 && $stable(cmd_s1))
		else $error("blocked command lost from input register");
`endif

endmodule

[sv/ferl_ctrl.sv]
`timescale 1ns / 1ps

// Write pointer, fill count and sequence counter; works out the store slot
// for each command.
module ferl_ctrl import ferl_pkg::*; #(
	parameter int LOG_DEPTH = 16,
	localparam int PW = $clog2(LOG_DEPTH),
	localparam int CW = $clog2(LOG_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [1:0]    cmd,
	input  logic [7:0]    read_index,
	output ferl_mem_ctl_t mem_ctl,
	output logic [PW-1:0] addr,
	output logic [31:0]   serial,
	output logic          found,
	output logic [CW-1:0] total
);

	localparam int SW = ((CW > 8) ? CW : 8) + 2;

	logic [PW-1:0] wp_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   serial_q;

	logic [PW-1:0] wp_nx;
	logic [CW-1:0] cnt_inc;
	logic [SW-1:0] idx_w;
	logic [SW-1:0] cnt_w;
	logic [SW-1:0] raw;
	logic [SW-1:0] slot_w;
	logic          hit;

	assign idx_w   = SW'(read_index);
	assign cnt_w   = SW'(cnt_q);
	assign hit     = idx_w < cnt_w;
	// oldest + index, modulo depth; below twice the depth whenever hit is set
	assign raw     = SW'(wp_q) + SW'(LOG_DEPTH) + idx_w - cnt_w;
	assign slot_w  = (raw >= SW'(LOG_DEPTH)) ? raw - SW'(LOG_DEPTH) : raw;
	assign wp_nx   = (wp_q == PW'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign cnt_inc = (cnt_q == CW'(LOG_DEPTH)) ? cnt_q : cnt_q + 1'b1;
	assign serial  = serial_q + 32'd1;

	always_comb begin
		mem_ctl = '0;
		addr    = wp_q;
		found   = 1'b0;
		total   = cnt_q;
		case (cmd)
			CMD_LOG: begin
				mem_ctl.wr = fire;
				total      = cnt_inc;
			end
			CMD_READ: begin
				mem_ctl.rd = fire && hit;
				addr       = slot_w[PW-1:0];
				found      = hit;
			end
			CMD_CLEAR: begin
				total = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			serial_q <= '0;
		end else if (fire) begin
			case (cmd)
				CMD_LOG: begin
					wp_q     <= wp_nx;
					cnt_q    <= cnt_inc;
					serial_q <= serial;
				end
				CMD_CLEAR: begin
					wp_q     <= '0;
					cnt_q    <= '0;
					serial_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LOG_DEPTH))
		else $error("fill count past depth");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PW'(LOG_DEPTH - 1))
		else $error("write pointer past depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd == CMD_CLEAR) |=> (cnt_q == '0) && (serial_q == '0))
		else $error("clear left state behind");
`endif

endmodule

[sv/ferl_store.sv]
`timescale 1ns / 1ps

// Event store: one port, shared by the write and the registered read.
module ferl_store import ferl_pkg::*; #(
	parameter int LOG_DEPTH = 16,
	localparam int PW = $clog2(LOG_DEPTH)
) (
	input  logic          clk,
	input  ferl_mem_ctl_t mem_ctl,
	input  logic [PW-1:0] addr,
	input  ferl_entry_t   wdata,
	output ferl_entry_t   rdata
);

	ferl_entry_t mem [LOG_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (mem_ctl.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule
